FILE: design/fjsop_pkg.sv
// ----------------------------------------------------------------------------
// fjsop_pkg: shared types and codes for the flat JSON string-object parser
// Holds the input and result word layouts, the token kinds, the status codes
// and the byte values that the grammar recognizes.
// ----------------------------------------------------------------------------
package fjsop_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 2;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             start_of_text;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0]   char_out;
    logic [KindW-1:0]   token_kind;
    logic [StatusW-1:0] parse_status;
  } out_word_t;

  // Token kinds
  localparam logic [KindW-1:0] TkNone    = 3'd0;
  localparam logic [KindW-1:0] TkKeyChar = 3'd1;
  localparam logic [KindW-1:0] TkKeyEnd  = 3'd2;
  localparam logic [KindW-1:0] TkValChar = 3'd3;
  localparam logic [KindW-1:0] TkPairEnd = 3'd4;

  // Parse status codes
  localparam logic [StatusW-1:0] StRunning = 2'd0;
  localparam logic [StatusW-1:0] StDone    = 2'd1;
  localparam logic [StatusW-1:0] StNoBrace = 2'd2;
  localparam logic [StatusW-1:0] StBad     = 2'd3;

  // Bytes of the grammar
  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChNl     = 8'h0A;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChQuote  = 8'h22;
  localparam logic [CharW-1:0] ChComma  = 8'h2C;
  localparam logic [CharW-1:0] ChColon  = 8'h3A;
  localparam logic [CharW-1:0] ChBslash = 8'h5C;
  localparam logic [CharW-1:0] ChLbrace = 8'h7B;
  localparam logic [CharW-1:0] ChRbrace = 8'h7D;

endpackage

FILE: design/fjsop_fsm.sv
// ----------------------------------------------------------------------------
// fjsop_fsm: parse state machine
// Takes one byte per accepted word, advances the parse phase and registers
// the token and the sticky status that the byte produces.
// ----------------------------------------------------------------------------
module fjsop_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  fjsop_pkg::in_word_t  in_word_i,
  output fjsop_pkg::out_word_t out_word_o
);

  typedef enum logic [3:0] {
    PhSeek    = 4'd0,
    PhBetween = 4'd1,
    PhKey     = 4'd2,
    PhKeyEsc  = 4'd3,
    PhColon   = 4'd4,
    PhPreval  = 4'd5,
    PhValue   = 4'd6,
    PhValEsc  = 4'd7,
    PhDone    = 4'd8,
    PhNoBrace = 4'd9,
    PhBad     = 4'd10
  } phase_e;

  phase_e                           phase_q, phase_d, phase_cur;
  fjsop_pkg::out_word_t             out_word_q, out_word_d;
  logic [fjsop_pkg::CharW-1:0]      c;
  logic                             is_blank;

  assign c        = in_word_i.char_in;
  assign is_blank = (c == fjsop_pkg::ChSpace) || (c == fjsop_pkg::ChTab);

  always_comb begin
    // A restart takes this byte as the first of a new text
    phase_cur = in_word_i.start_of_text ? PhSeek : phase_q;
    phase_d   = phase_cur;
    out_word_d.char_out   = fjsop_pkg::ChNul;
    out_word_d.token_kind = fjsop_pkg::TkNone;

    unique case (phase_cur)
      PhSeek: begin
        if (c == fjsop_pkg::ChNul) phase_d = PhNoBrace;
        else if (c == fjsop_pkg::ChLbrace) phase_d = PhBetween;
      end
      PhBetween: begin
        if (is_blank || c == fjsop_pkg::ChNl || c == fjsop_pkg::ChComma) begin
          phase_d = PhBetween;
        end else if (c == fjsop_pkg::ChRbrace || c == fjsop_pkg::ChNul) begin
          phase_d = PhDone;
        end else if (c == fjsop_pkg::ChQuote) begin
          phase_d = PhKey;
        end else begin
          phase_d = PhBad;
        end
      end
      PhKey: begin
        if (c == fjsop_pkg::ChNul) begin
          phase_d = PhBad;
        end else if (c == fjsop_pkg::ChBslash) begin
          phase_d = PhKeyEsc;
        end else if (c == fjsop_pkg::ChQuote) begin
          out_word_d.token_kind = fjsop_pkg::TkKeyEnd;
          phase_d = PhColon;
        end else begin
          out_word_d.token_kind = fjsop_pkg::TkKeyChar;
          out_word_d.char_out   = c;
        end
      end
      PhKeyEsc: begin
        if (c == fjsop_pkg::ChNul) begin
          phase_d = PhBad;
        end else begin
          out_word_d.token_kind = fjsop_pkg::TkKeyChar;
          out_word_d.char_out   = c;
          phase_d = PhKey;
        end
      end
      PhColon: begin
        if (is_blank) phase_d = PhColon;
        else if (c == fjsop_pkg::ChColon) phase_d = PhPreval;
        else phase_d = PhBad;
      end
      PhPreval: begin
        if (is_blank) phase_d = PhPreval;
        else if (c == fjsop_pkg::ChQuote) phase_d = PhValue;
        else phase_d = PhBad;
      end
      PhValue: begin
        if (c == fjsop_pkg::ChNul) begin
          phase_d = PhBad;
        end else if (c == fjsop_pkg::ChBslash) begin
          phase_d = PhValEsc;
        end else if (c == fjsop_pkg::ChQuote) begin
          out_word_d.token_kind = fjsop_pkg::TkPairEnd;
          phase_d = PhBetween;
        end else begin
          out_word_d.token_kind = fjsop_pkg::TkValChar;
          out_word_d.char_out   = c;
        end
      end
      PhValEsc: begin
        if (c == fjsop_pkg::ChNul) begin
          phase_d = PhBad;
        end else begin
          out_word_d.token_kind = fjsop_pkg::TkValChar;
          out_word_d.char_out   = c;
          phase_d = PhValue;
        end
      end
      // Final phases hold until a restart
      PhDone, PhNoBrace, PhBad: phase_d = phase_cur;
      default: phase_d = PhBad;
    endcase

    unique case (phase_d)
      PhDone:    out_word_d.parse_status = fjsop_pkg::StDone;
      PhNoBrace: out_word_d.parse_status = fjsop_pkg::StNoBrace;
      PhBad:     out_word_d.parse_status = fjsop_pkg::StBad;
      default:   out_word_d.parse_status = fjsop_pkg::StRunning;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhSeek;
      out_word_q <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      out_word_q <= out_word_d;
    end
  end

  assign out_word_o = out_word_q;

endmodule

FILE: design/flat_json_string_object_parser.sv
// ----------------------------------------------------------------------------
// flat_json_string_object_parser: streaming parser for {"key":"value",...}
// One byte in, one token and status word out, one byte per clock unless the sink stalls.
// ----------------------------------------------------------------------------
// Feed the text one byte per input word; a word with start_of_text high
// restarts the parse at that byte, and a zero byte ends the text. Every
// accepted byte yields exactly one result word carrying the key or value
// byte, the token kind and the sticky status. The block sustains one byte
// per clock unless the sink stalls: the phase update and token decode are
// combinational, and the result appears in the cycle after the byte is
// accepted, from a single result register. A new byte is taken whenever that
// register is empty or is being read in the same cycle.
module flat_json_string_object_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fjsop_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fjsop_pkg::out_word_t out_word_o
);

  logic out_valid_q, out_valid_d;
  logic accept;

  // Hold new bytes only while a result waits and the sink stalls
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  fjsop_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

  assign out_valid_o = out_valid_q;

  a_token_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.token_kind != fjsop_pkg::TkNone)
      |-> out_word_o.parse_status == fjsop_pkg::StRunning)
    else $error("token emitted with a final status");

  a_char_only_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.token_kind != fjsop_pkg::TkKeyChar)
      && (out_word_o.token_kind != fjsop_pkg::TkValChar)
      |-> out_word_o.char_out == fjsop_pkg::ChNul)
    else $error("char_out nonzero on a non-content token");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted byte produced no result");

endmodule
